// ===== hdl/slt_pkg.sv =====
package slt_pkg;

  typedef struct packed {
    logic [14:0]        lightness;
    logic signed [15:0] chroma_a;
    logic signed [15:0] chroma_b;
    logic [15:0]        extra_channel;
    logic               end_of_frame;
  } pix_in_t;

  typedef struct packed {
    logic [14:0]        out_lightness;
    logic signed [15:0] out_chroma_a;
    logic signed [15:0] out_chroma_b;
    logic [15:0]        out_extra_channel;
    logic               out_end_of_frame;
  } pix_out_t;

  typedef struct packed {
    logic signed [15:0] shadow_tint_a;
    logic signed [15:0] shadow_tint_b;
    logic signed [15:0] highlight_tint_a;
    logic signed [15:0] highlight_tint_b;
    logic [14:0]        balance_level;
    logic [14:0]        compress_width;
  } cfg_t;

  // weight stage to blend stage
  typedef struct packed {
    logic               valid;
    logic [16:0]        ra;
    logic signed [15:0] ta;
    logic signed [15:0] tb;
    pix_in_t            pix;
  } wt_t;

  typedef enum logic [2:0] {
    CFG_SHADOW_A    = 3'd0,
    CFG_SHADOW_B    = 3'd1,
    CFG_HIGHLIGHT_A = 3'd2,
    CFG_HIGHLIGHT_B = 3'd3,
    CFG_BALANCE     = 3'd4,
    CFG_COMPRESS    = 3'd5
  } cfg_idx_t;

  localparam logic [14:0] BALANCE_RST  = 15'd12800;
  localparam logic [14:0] COMPRESS_RST = 15'd8448;

  // weight = min(1, d / 25600) in Q16; below saturation it is floor((64d + 12) / 25)
  localparam logic [16:0] RA_ONE      = 17'd65536;
  localparam logic [17:0] SAT_DIST    = 18'd25600;
  localparam logic [20:0] RA_BIAS     = 21'd12;
  localparam logic [21:0] DIV_C       = 22'd25;
  localparam int          RECIP_SHIFT = 26;
  localparam logic [21:0] RECIP_K     = 22'd2684354;

endpackage

// ===== hdl/slt_cfg.sv =====
module slt_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [2:0]          wr_index,
  input  logic [15:0]         wr_data,
  output slt_pkg::cfg_t       cfg
);
  import slt_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        CFG_SHADOW_A:    cfg_nxt.shadow_tint_a    = wr_data;
        CFG_SHADOW_B:    cfg_nxt.shadow_tint_b    = wr_data;
        CFG_HIGHLIGHT_A: cfg_nxt.highlight_tint_a = wr_data;
        CFG_HIGHLIGHT_B: cfg_nxt.highlight_tint_b = wr_data;
        CFG_BALANCE:     cfg_nxt.balance_level    = wr_data[14:0];
        CFG_COMPRESS:    cfg_nxt.compress_width   = wr_data[14:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shadow_tint_a    <= '0;
      cfg_r.shadow_tint_b    <= '0;
      cfg_r.highlight_tint_a <= '0;
      cfg_r.highlight_tint_b <= '0;
      cfg_r.balance_level    <= BALANCE_RST;
      cfg_r.compress_width   <= COMPRESS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/slt_weight.sv =====
module slt_weight (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  slt_pkg::pix_in_t in_pix,
  input  slt_pkg::cfg_t    cfg,
  output slt_pkg::wt_t     wt
);
  import slt_pkg::*;

  logic signed [17:0] l2, b2, w, lo, hi, gap;
  logic               below, above, sat;
  logic [20:0]        m;

  // stage 1: band test, distance
  logic               v1_r, out1_r, sat1_r;
  logic [20:0]        m1_r;
  logic signed [15:0] ta1_r, tb1_r;
  pix_in_t            pix1_r;

  // stage 2: reciprocal product
  logic               v2_r, out2_r, sat2_r;
  logic [20:0]        m2_r;
  logic [42:0]        prod2_r;
  logic signed [15:0] ta2_r, tb2_r;
  pix_in_t            pix2_r;

  // stage 3: quotient correction
  logic [16:0]        q0, q;
  logic [21:0]        q25, rem;
  wt_t                wt_r, wt_nxt;

  always_comb begin
    l2    = $signed({2'b00, in_pix.lightness, 1'b0});
    b2    = $signed({2'b00, cfg.balance_level, 1'b0});
    w     = $signed({3'b000, cfg.compress_width});
    lo    = b2 - w;
    hi    = b2 + w;
    below = l2 < lo;
    above = l2 > hi;
    gap   = below ? (lo - l2) : (l2 - hi);
    sat   = gap >= $signed(SAT_DIST);
    m     = {gap[14:0], 6'b0} + RA_BIAS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    out1_r  <= below | above;
    sat1_r  <= sat;
    m1_r    <= m;
    ta1_r   <= below ? cfg.shadow_tint_a : cfg.highlight_tint_a;
    tb1_r   <= below ? cfg.shadow_tint_b : cfg.highlight_tint_b;
    pix1_r  <= in_pix;

    out2_r  <= out1_r;
    sat2_r  <= sat1_r;
    m2_r    <= m1_r;
    prod2_r <= {22'b0, m1_r} * {21'b0, RECIP_K};
    ta2_r   <= ta1_r;
    tb2_r   <= tb1_r;
    pix2_r  <= pix1_r;
  end

  always_comb begin
    q0  = prod2_r[RECIP_SHIFT+16:RECIP_SHIFT];
    q25 = {5'b0, q0} * DIV_C;
    rem = {1'b0, m2_r} - q25;
    q   = (rem >= DIV_C) ? (q0 + 17'd1) : q0;
    wt_nxt.valid = v2_r;
    wt_nxt.ra    = !out2_r ? 17'd0 : (sat2_r ? RA_ONE : q);
    wt_nxt.ta    = ta2_r;
    wt_nxt.tb    = tb2_r;
    wt_nxt.pix   = pix2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wt_r.valid <= 1'b0;
    end else begin
      wt_r.valid <= wt_nxt.valid;
    end
    wt_r.ra  <= wt_nxt.ra;
    wt_r.ta  <= wt_nxt.ta;
    wt_r.tb  <= wt_nxt.tb;
    wt_r.pix <= wt_nxt.pix;
  end

  assign wt = wt_r;

endmodule

// ===== hdl/slt_blend.sv =====
module slt_blend (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic signed [15:0] x,
  input  logic signed [15:0] tint,
  input  logic [16:0]        ra,
  output logic               out_valid,
  output logic signed [15:0] y
);
  import slt_pkg::*;

  // y = floor((x * 2^16 + (tint - x) * ra + 2^15) / 2^16)
  logic signed [16:0] diff;
  logic signed [34:0] prod;
  logic               va_r, vb_r;
  logic signed [34:0] prod_r;
  logic signed [15:0] x_r;
  logic signed [35:0] sum;
  logic signed [15:0] y_r;

  always_comb begin
    diff = 17'(tint) - 17'(x);
    prod = 35'(diff) * 35'($signed({1'b0, ra}));
    sum  = 36'($signed({x_r, 16'b0})) + 36'(prod_r) + 36'sd32768;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod;
    x_r    <= x;
    y_r    <= sum[31:16];
  end

  assign out_valid = vb_r;
  assign y         = y_r;

endmodule

// ===== hdl/lab_split_toning_pixel.sv =====
//  channel  ports                                    direction
//  input    start, busy, in_data                     pixel in
//  result   out_valid, out_data                      toned pixel out
//  config   cfg_valid, cfg_ready, cfg_index, cfg_data register write
//
//  One pixel per clock; each input transfer yields one result transfer.
//  The five stages: band test, reciprocal multiply, weight correction,
//  blend multiply, round. busy stays low and cfg_ready stays high.
//  Synchronous active-low reset clears the valid bits and loads register defaults.
//  The receiver cannot stall, so the pipeline always advances.
module lab_split_toning_pixel (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  slt_pkg::pix_in_t  in_data,
  output logic              out_valid,
  output slt_pkg::pix_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import slt_pkg::*;

  cfg_t               cfg;
  wt_t                wt;
  logic               va, vb;
  logic signed [15:0] ya, yb;
  pix_in_t            pix4_r, pix5_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  slt_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  slt_weight u_weight (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start & ~busy),
    .in_pix   (in_data),
    .cfg      (cfg),
    .wt       (wt)
  );

  slt_blend u_blend_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (wt.valid),
    .x         (wt.pix.chroma_a),
    .tint      (wt.ta),
    .ra        (wt.ra),
    .out_valid (va),
    .y         (ya)
  );

  slt_blend u_blend_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (wt.valid),
    .x         (wt.pix.chroma_b),
    .tint      (wt.tb),
    .ra        (wt.ra),
    .out_valid (vb),
    .y         (yb)
  );

  always_ff @(posedge clk) begin
    pix4_r <= wt.pix;
    pix5_r <= pix4_r;
  end

  always_comb begin
    out_valid                  = va & vb;
    out_data.out_lightness     = pix5_r.lightness;
    out_data.out_chroma_a      = ya;
    out_data.out_chroma_b      = yb;
    out_data.out_extra_channel = pix5_r.extra_channel;
    out_data.out_end_of_frame  = pix5_r.end_of_frame;
  end

endmodule
